// ===== hdl/est_pkg.sv =====
`timescale 1ns / 1ps
package est_pkg;

  localparam int unsigned QueueDepthDefault = 4;

  localparam logic [7:0] CharBackslash = 8'h5c;
  localparam logic [7:0] CharLowerX    = 8'h78;

  // one queue entry: up to three bytes caused by one input transaction
  typedef struct packed {
    logic [2:0][7:0] bytes;   // bytes[0] goes out first
    logic [1:0]      count;   // 1 to 3
    logic            done;    // input carried the end-of-text mark
  } est_entry_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] code;
  } ctrl_t;

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_dec(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  function automatic logic [3:0] nibble(input logic [7:0] c);
    logic [3:0] n;
    n = 4'd0;
    if (is_dec(c)) begin
      n = c[3:0];
    end else if (is_hex(c)) begin
      n = c[3:0] + 4'd9;  // 'a'/'A' have low nibble 1
    end
    return n;
  endfunction

  function automatic ctrl_t control_code(input logic [7:0] c);
    ctrl_t r;
    r.hit  = 1'b1;
    r.code = 8'h00;
    case (c | 8'h20)
      8'h61: r.code = 8'h07;  // a
      8'h62: r.code = 8'h08;  // b
      8'h66: r.code = 8'h0c;  // f
      8'h6e: r.code = 8'h0a;  // n
      8'h72: r.code = 8'h0d;  // r
      8'h74: r.code = 8'h09;  // t
      8'h76: r.code = 8'h0b;  // v
      8'h65: r.code = 8'h1b;  // e
      default: r.hit = 1'b0;
    endcase
    // only letters fold by case; the OR also maps some non-letters
    if ((c < 8'h41) || ((c > 8'h5a) && (c < 8'h61))) begin
      r.hit = 1'b0;
    end
    return r;
  endfunction

endpackage

// ===== hdl/est_front.sv =====
`timescale 1ns / 1ps
module est_front import est_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       escape_enable,
  input  logic       accept,
  input  logic [7:0] in_char,
  input  logic       end_of_text,
  output logic       push,
  output est_entry_t push_entry
);

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_SLASH  = 3'd1,
    MODE_DEC1   = 3'd2,
    MODE_DEC2   = 3'd3,
    MODE_HEX1   = 3'd4,
    MODE_HEX2   = 3'd5
  } mode_t;

  mode_t      parse_mode, parse_mode_next;
  logic [7:0] held_first, held_first_next;
  logic [7:0] held_second, held_second_next;

  logic [7:0] bytes [3];
  logic [1:0] n;
  logic       run_plain;
  logic [7:0] dec_value;
  ctrl_t      ctrl;

  assign ctrl      = control_code(in_char);
  assign dec_value = {held_first[1:0], 6'b0} | {1'b0, held_second[3:0], 3'b0}
                   | {4'b0, in_char[3:0]};

  always_comb begin
    parse_mode_next  = MODE_NORMAL;
    held_first_next  = held_first;
    held_second_next = held_second;
    bytes[0] = 8'h00;
    bytes[1] = 8'h00;
    bytes[2] = 8'h00;
    n         = 2'd0;
    run_plain = 1'b0;

    if (!escape_enable) begin
      bytes[0] = in_char;
      n = 2'd1;
    end else begin
      case (parse_mode)
        MODE_SLASH: begin
          if (ctrl.hit) begin
            bytes[0] = ctrl.code;
            n = 2'd1;
          end else if (is_dec(in_char) && !end_of_text) begin
            held_first_next = in_char;
            parse_mode_next = MODE_DEC1;
          end else if ((in_char == CharLowerX) && !end_of_text) begin
            parse_mode_next = MODE_HEX1;
          end else begin
            bytes[0] = in_char;
            n = 2'd1;
          end
        end
        MODE_DEC1: begin
          if (is_dec(in_char) && !end_of_text) begin
            held_second_next = in_char;
            parse_mode_next  = MODE_DEC2;
          end else begin
            bytes[0] = held_first;
            n = 2'd1;
            run_plain = 1'b1;
          end
        end
        MODE_DEC2: begin
          if (is_dec(in_char)) begin
            bytes[0] = dec_value;
            n = 2'd1;
          end else begin
            bytes[0] = held_first;
            bytes[1] = held_second;
            n = 2'd2;
            run_plain = 1'b1;
          end
        end
        MODE_HEX1: begin
          if (is_hex(in_char) && !end_of_text) begin
            held_first_next = in_char;
            parse_mode_next = MODE_HEX2;
          end else begin
            bytes[0] = CharLowerX;
            n = 2'd1;
            run_plain = 1'b1;
          end
        end
        MODE_HEX2: begin
          if (is_hex(in_char)) begin
            bytes[0] = {nibble(held_first), nibble(in_char)};
            n = 2'd1;
          end else begin
            bytes[0] = CharLowerX;
            bytes[1] = held_first;
            n = 2'd2;
            run_plain = 1'b1;
          end
        end
        default: run_plain = 1'b1;
      endcase

      // reprocess the byte as plain text: it may open a new escape
      if (run_plain) begin
        if ((in_char == CharBackslash) && !end_of_text) begin
          parse_mode_next = MODE_SLASH;
        end else begin
          bytes[n] = in_char;
          n = n + 2'd1;
        end
      end
    end

    if (end_of_text) begin
      parse_mode_next  = MODE_NORMAL;
      held_first_next  = 8'h00;
      held_second_next = 8'h00;
    end
  end

  assign push             = accept && (n != 2'd0);
  assign push_entry.bytes = {bytes[2], bytes[1], bytes[0]};
  assign push_entry.count = n;
  assign push_entry.done  = end_of_text;

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_mode  <= MODE_NORMAL;
      held_first  <= 8'h00;
      held_second <= 8'h00;
    end else if (accept) begin
      parse_mode  <= parse_mode_next;
      held_first  <= held_first_next;
      held_second <= held_second_next;
    end
  end

endmodule

// ===== hdl/est_queue.sv =====
`timescale 1ns / 1ps
module est_queue import est_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  est_entry_t push_entry,
  output logic       full,
  input  logic       pop,
  output logic       head_valid,
  output est_entry_t head
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);

  est_entry_t     slots [QueueDepth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push, do_pop;

  assign full       = (count == FullCnt);
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/est_back.sv =====
`timescale 1ns / 1ps
module est_back import est_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  est_entry_t head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       last_of_run,
  output logic       text_done
);

  logic [1:0] idx;
  logic       load;
  logic       at_last;

  assign load    = head_valid && (!out_valid || out_ready);
  assign at_last = (idx == (head.count - 2'd1));
  assign pop     = load && at_last;

  // control: output valid and byte index within the head entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= at_last ? 2'd0 : idx + 2'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_char    <= head.bytes[idx];
      last_of_run <= at_last;
      text_done   <= at_last && head.done;
    end
  end

endmodule

// ===== hdl/escape_sequence_translator.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Transaction moves
// s_axis    in         one source byte and its end-of-text mark
// m_axis    out        one translated byte, end-of-run flag, end-of-text mark
// cfg       in         escape_enable write, taken whenever cfg_wr_en is high
//
// Input accepts one transaction per cycle while the entry queue has room; the
// front decodes it in the same cycle and pushes it to the queue. The back sends
// one byte per cycle while the receiver is ready, one output transaction per
// byte; the queue (QueueDepth entries) absorbs bursts. Output bytes are
// registered. Reset (rst, synchronous) clears parse state, queue and output
// valid; the escape_enable register resets to 0 (pass-through).
module escape_sequence_translator import est_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic       clk,
  input  logic       rst,
  // configuration
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,     // escape_enable
  // input stream
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,    // [7:0] in_char
  input  logic       s_axis_tlast,    // end_of_text
  // output stream
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,    // [7:0] out_char
  output logic       m_axis_tuser,    // last_of_run
  output logic       m_axis_tlast     // text_done
);

  logic       escape_enable;
  logic       accept;
  logic       push;
  est_entry_t push_entry;
  logic       full;
  logic       pop;
  logic       head_valid;
  est_entry_t head;

  // hold the mode bit; the user must write it only while the block is idle; the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      escape_enable <= 1'b0;
    end else if (cfg_wr_en) begin
      escape_enable <= cfg_wr_data;
    end
  end

  // stall input only when the queue is full; a pending output does not block
  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // front: classify each byte and build the bytes it causes
  est_front u_front (
    .clk           (clk),
    .rst           (rst),
    .escape_enable (escape_enable),
    .accept        (accept),
    .in_char       (s_axis_tdata),
    .end_of_text   (s_axis_tlast),
    .push          (push),
    .push_entry    (push_entry)
  );

  // queue: decouple decode from byte-by-byte delivery
  est_queue #(
    .QueueDepth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // back: advance through each entry one byte per output transaction
  est_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_char    (m_axis_tdata),
    .last_of_run (m_axis_tuser),
    .text_done   (m_axis_tlast)
  );

endmodule

// ===== tb/sv/tb_escape_sequence_translator.sv =====
`timescale 1ns / 1ps
module tb_escape_sequence_translator import est_pkg::*; ();

  // Control codes produced by the single-letter escapes
  localparam logic [7:0] CodeBell      = 8'h07;
  localparam logic [7:0] CodeBackspace = 8'h08;
  localparam logic [7:0] CodeFormFeed  = 8'h0c;
  localparam logic [7:0] CodeLineFeed  = 8'h0a;
  localparam logic [7:0] CodeReturn    = 8'h0d;
  localparam logic [7:0] CodeTab       = 8'h09;
  localparam logic [7:0] CodeVtab      = 8'h0b;
  localparam logic [7:0] CodeEscape    = 8'h1b;

  // Cycles without any transaction on either stream before giving up
  localparam int WatchdogLimit = 1000;
  // Length of the forced output hold-off that backs the block up
  localparam int HoldOffCycles = 150;
  // Cycles to let a result-less input settle before a register write
  localparam int SettleCycles  = 4;

  typedef enum logic [2:0] {
    ScanText, ScanSlash, ScanDec1, ScanDec2, ScanHex1, ScanHex2
  } scan_state_t;

  // One output transaction as seen on m_axis
  typedef struct packed {
    logic [7:0] ch;
    logic       run_end;    // tuser: last byte caused by one input
    logic       text_end;   // tlast: last byte of the whole text
  } out_byte_t;

  // One row of the directed table; "typed" rows carry their single
  // expected byte, all others go through the translator model
  typedef struct packed {
    logic       esc;
    logic [7:0] ch;
    logic       eot;
    logic       typed;
    logic [7:0] want;
  } text_row_t;

  localparam int NumDirected = 26;
  localparam text_row_t DirectedText [NumDirected] = '{
    // escapes off after reset: extremes and a backslash pass untouched
    '{1'b0, 8'h00,         1'b0, 1'b1, 8'h00},
    '{1'b0, 8'hff,         1'b0, 1'b1, 8'hff},
    '{1'b0, CharBackslash, 1'b1, 1'b1, CharBackslash},
    // control letter
    '{1'b1, CharBackslash, 1'b0, 1'b0, 8'h00},
    '{1'b1, "n",           1'b0, 1'b1, CodeLineFeed},
    // largest decimal escape, 8 and 9 overlap into neighbor bits
    '{1'b1, CharBackslash, 1'b0, 1'b0, 8'h00},
    '{1'b1, "9",           1'b0, 1'b0, 8'h00},
    '{1'b1, "9",           1'b0, 1'b0, 8'h00},
    '{1'b1, "9",           1'b0, 1'b0, 8'h00},
    // hex escape with mixed case digits
    '{1'b1, CharBackslash, 1'b0, 1'b0, 8'h00},
    '{1'b1, CharLowerX,    1'b0, 1'b0, 8'h00},
    '{1'b1, "F",           1'b0, 1'b0, 8'h00},
    '{1'b1, "f",           1'b0, 1'b1, 8'hff},
    // hex escape broken by a non-hex character
    '{1'b1, CharBackslash, 1'b0, 1'b0, 8'h00},
    '{1'b1, CharLowerX,    1'b0, 1'b0, 8'h00},
    '{1'b1, "g",           1'b0, 1'b0, 8'h00},
    // decimal escape broken after two digits: three bytes out
    '{1'b1, CharBackslash, 1'b0, 1'b0, 8'h00},
    '{1'b1, "1",           1'b0, 1'b0, 8'h00},
    '{1'b1, "2",           1'b0, 1'b0, 8'h00},
    '{1'b1, "z",           1'b0, 1'b0, 8'h00},
    // unknown escape letter comes out as itself
    '{1'b1, CharBackslash, 1'b0, 1'b0, 8'h00},
    '{1'b1, "q",           1'b0, 1'b1, "q"},
    // lone backslash as the final byte of the text
    '{1'b1, CharBackslash, 1'b1, 1'b1, CharBackslash},
    // text ends while a hex escape is open
    '{1'b1, CharBackslash, 1'b0, 1'b0, 8'h00},
    '{1'b1, CharLowerX,    1'b0, 1'b0, 8'h00},
    '{1'b1, "A",           1'b1, 1'b0, 8'h00}
  };

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_wr_en;
  logic       cfg_wr_data;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;    // [7:0] in_char
  logic       s_axis_tlast;    // end_of_text
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;    // [7:0] out_char
  logic       m_axis_tuser;    // last_of_run
  logic       m_axis_tlast;    // text_done

  escape_sequence_translator DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Translator model state, a mirror of the block's parse state
  logic        escapes_on = 1'b0;
  scan_state_t scan_state = ScanText;
  logic [7:0]  held_a = 8'h00;
  logic [7:0]  held_b = 8'h00;
  logic [7:0]  run_bytes[$];       // bytes produced by the latest input
  out_byte_t   expected_out[$];    // translated bytes still owed by the block

  int          mismatches = 0;
  int          items_sent = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  logic        hold_off_req = 1'b0;
  logic        hold_off_done = 1'b0;
  int          hold_left = 0;
  int          quiet_cycles = 0;

  string       ControlLetters = "abfnrtveABFNRTVE";
  string       HexDigits = "0123456789abcdefABCDEF";

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_hex_digit(input logic [7:0] c);
    return is_digit(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    if (is_digit(c)) begin
      v = c - "0";
    end else if ((c >= "a") && (c <= "f")) begin
      v = c - "a" + 8'd10;
    end else begin
      v = c - "A" + 8'd10;
    end
    return v[3:0];
  endfunction

  // {hit, code} for the single-letter escapes, either case
  function automatic logic [8:0] control_of(input logic [7:0] c);
    case (c)
      "a", "A": return {1'b1, CodeBell};
      "b", "B": return {1'b1, CodeBackspace};
      "f", "F": return {1'b1, CodeFormFeed};
      "n", "N": return {1'b1, CodeLineFeed};
      "r", "R": return {1'b1, CodeReturn};
      "t", "T": return {1'b1, CodeTab};
      "v", "V": return {1'b1, CodeVtab};
      "e", "E": return {1'b1, CodeEscape};
      default:  return 9'd0;
    endcase
  endfunction

  // Append one byte to the result of the latest input
  function automatic void add_run_byte(input logic [7:0] c);
    run_bytes = {run_bytes, c};
  endfunction

  // Ordinary text: a backslash opens an escape unless the text ends here
  function automatic void take_as_text(input logic [7:0] c, input logic eot);
    if (c == CharBackslash && !eot) begin
      scan_state = ScanSlash;
    end else begin
      add_run_byte(c);
    end
  endfunction

  // Advance the translator model by one input byte; results land in run_bytes
  function automatic void translate_byte(input logic [7:0] c, input logic eot);
    scan_state_t from;
    logic [8:0]  ctrl;
    logic [7:0]  dec_byte;
    from = scan_state;
    scan_state = ScanText;
    run_bytes.delete();
    if (!escapes_on) begin
      add_run_byte(c);
    end else begin
      case (from)
        ScanSlash: begin
          ctrl = control_of(c);
          if (ctrl[8]) begin
            add_run_byte(ctrl[7:0]);
          end else if (is_digit(c) && !eot) begin
            held_a = c;
            scan_state = ScanDec1;
          end else if (c == CharLowerX && !eot) begin
            scan_state = ScanHex1;
          end else begin
            add_run_byte(c);
          end
        end
        ScanDec1: begin
          if (is_digit(c) && !eot) begin
            held_b = c;
            scan_state = ScanDec2;
          end else begin
            add_run_byte(held_a);
            take_as_text(c, eot);
          end
        end
        ScanDec2: begin
          if (is_digit(c)) begin
            // 8-bit context drops the overflow of digits 8 and 9
            dec_byte = ((held_a - "0") << 6) | ((held_b - "0") << 3) | (c - "0");
            add_run_byte(dec_byte);
          end else begin
            add_run_byte(held_a);
            add_run_byte(held_b);
            take_as_text(c, eot);
          end
        end
        ScanHex1: begin
          if (is_hex_digit(c) && !eot) begin
            held_a = c;
            scan_state = ScanHex2;
          end else begin
            add_run_byte(CharLowerX);
            take_as_text(c, eot);
          end
        end
        ScanHex2: begin
          if (is_hex_digit(c)) begin
            add_run_byte({hex_value(held_a), hex_value(c)});
          end else begin
            add_run_byte(CharLowerX);
            add_run_byte(held_a);
            take_as_text(c, eot);
          end
        end
        default: take_as_text(c, eot);
      endcase
    end
    if (eot) begin
      scan_state = ScanText;
      held_a = 8'h00;
      held_b = 8'h00;
    end
  endfunction

  // Offer one byte, maybe after an idle gap, and hold it until the block
  // takes the transaction; then queue the bytes it must produce
  task automatic send_byte(input logic [7:0] c, input logic eot,
                           input logic typed, input logic [7:0] want);
    int        i;
    out_byte_t ob;
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= eot;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
    translate_byte(c, eot);
    if (typed) begin
      ob.ch = want;
      ob.run_end = 1'b1;
      ob.text_end = eot;
      expected_out = {expected_out, ob};
    end else begin
      for (i = 0; i < run_bytes.size(); i++) begin
        ob.ch = run_bytes[i];
        ob.run_end = (i == run_bytes.size() - 1);
        ob.text_end = eot && ob.run_end;
        expected_out = {expected_out, ob};
      end
    end
  endtask

  task automatic send_text_byte(input logic [7:0] c);
    send_byte(c, $urandom_range(15) == 0, 1'b0, 8'h00);
  endtask

  // Drain the block, let any result-less input settle, then write the register
  task automatic set_escapes(input logic on);
    s_axis_tvalid <= 1'b0;
    while (expected_out.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= on;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    escapes_on = on;
  endtask

  // Well-formed escapes with random content as the largest share, plus loose bytes,
  // broken escapes and arbitrary characters after a backslash
  task automatic send_random_text(input int count);
    int stop_at;
    int kind;
    int shape;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      kind = $urandom_range(99);
      if (kind < 25) begin
        send_text_byte(8'($urandom_range(255)));
      end else begin
        send_text_byte(CharBackslash);
        if (kind < 40) begin
          send_text_byte(ControlLetters[$urandom_range(15)]);
        end else if (kind < 55) begin
          repeat (3) send_text_byte(8'(8'h30 + $urandom_range(9)));
        end else if (kind < 70) begin
          send_text_byte(CharLowerX);
          repeat (2) send_text_byte(HexDigits[$urandom_range(21)]);
        end else if (kind < 90) begin
          shape = $urandom_range(2);
          if (shape == 0) begin
            send_text_byte(8'(8'h30 + $urandom_range(9)));
          end else if (shape == 1) begin
            repeat (2) send_text_byte(8'(8'h30 + $urandom_range(9)));
          end else begin
            send_text_byte(CharLowerX);
            if ($urandom_range(1) == 1) send_text_byte(HexDigits[$urandom_range(21)]);
          end
          send_text_byte(8'($urandom_range(255)));
        end else begin
          send_text_byte(8'($urandom_range(255)));
        end
      end
    end
  endtask

  // Output side: random backpressure, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_off_req && !hold_off_done) begin
      hold_off_done <= 1'b1;
      hold_left <= HoldOffCycles;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Check every output transaction against the oldest owed byte
  always @(posedge clk) begin
    out_byte_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_out.size() == 0) begin
        $display("%0t: unexpected output: expected none, actual char %02h run %b done %b",
                 $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
        mismatches++;
      end else begin
        want = expected_out.pop_front();
        if (m_axis_tdata !== want.ch || m_axis_tuser !== want.run_end ||
            m_axis_tlast !== want.text_end) begin
          $display({"%0t: mismatch: expected char %02h run %b done %b, ",
                    "actual char %02h run %b done %b"},
                   $time, want.ch, want.run_end, want.text_end,
                   m_axis_tdata, m_axis_tuser, m_axis_tlast);
          mismatches++;
        end
      end
    end
  end

  // Abort when neither stream has moved for too long
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("[escape_sequence_translator] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int r;
    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tlast  = 1'b0;
    send_idle_pct = 10;
    recv_idle_pct = 48;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed table: switch the register whenever a row asks for it
    for (r = 0; r < NumDirected; r++) begin
      if (DirectedText[r].esc != escapes_on) set_escapes(DirectedText[r].esc);
      send_byte(DirectedText[r].ch, DirectedText[r].eot,
                DirectedText[r].typed, DirectedText[r].want);
    end

    // Sender idles rarely, receiver often
    send_random_text(70);

    // Receiver idles rarely, sender often; leave an escape open, then
    // disable so the first pass-through byte abandons it
    send_idle_pct = 48;
    recv_idle_pct = 10;
    send_byte(CharBackslash, 1'b0, 1'b0, 8'h00);
    set_escapes(1'b0);
    send_random_text(35);
    set_escapes(1'b1);
    send_random_text(45);

    // No idling; hold the output off for a long stretch so the block fills up
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_req = 1'b1;
    send_random_text(50);

    s_axis_tvalid <= 1'b0;
    while (expected_out.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("[escape_sequence_translator] OK");
    end else begin
      $display("[escape_sequence_translator] ERROR");
    end
    $finish;
  end

endmodule
